### rtl/ualu_pkg.sv
// Shared constants and types for the unsigned ALU with multiply, divide and factorial.
`default_nettype none

package ualu_pkg;

    // Widths fixed by the word format
    localparam int ACT_W     = 3;
    localparam int FIELD_W   = 32;
    localparam int DEF_WIDTH = 32;

    // Action codes carried by an input word
    localparam logic [ACT_W-1:0] ACT_ADD  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FACT = 3'd4;

    // Commands for the shared arithmetic unit
    localparam int UC_W = 3;
    localparam logic [UC_W-1:0] UC_NOP     = 3'd0;
    localparam logic [UC_W-1:0] UC_LOAD_HI = 3'd1;
    localparam logic [UC_W-1:0] UC_LOAD_LO = 3'd2;
    localparam logic [UC_W-1:0] UC_ADD     = 3'd3;
    localparam logic [UC_W-1:0] UC_SUB     = 3'd4;
    localparam logic [UC_W-1:0] UC_MUL     = 3'd5;
    localparam logic [UC_W-1:0] UC_DIV     = 3'd6;

    typedef struct packed {
        logic [UC_W-1:0] code;
    } t_unit_cmd;

endpackage

`default_nettype wire

### rtl/ualu_if.sv
// Valid/ready channel interfaces for operand words and result words.
`default_nettype none

interface ualu_in_if;
    logic                                valid;
    logic                                ready;
    logic [ualu_pkg::ACT_W-1:0]          action;
    logic [ualu_pkg::FIELD_W-1:0]        operand_a;
    logic [ualu_pkg::FIELD_W-1:0]        operand_b;

    modport source (output valid, output action, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input action, input operand_a, input operand_b,
                    output ready);
endinterface

interface ualu_out_if;
    logic                                valid;
    logic                                ready;
    logic [ualu_pkg::FIELD_W-1:0]        result;
    logic [ualu_pkg::FIELD_W-1:0]        remainder;
    logic                                flag;
    logic                                div_by_zero;

    modport source (output valid, output result, output remainder, output flag,
                    output div_by_zero, input ready);
    modport sink   (input valid, input result, input remainder, input flag,
                    input div_by_zero, output ready);
endinterface

`default_nettype wire

### rtl/ualu_unit.sv
// Shared add/subtract unit with shift-add multiply and restoring divide steps.
`default_nettype none

module ualu_unit #(
    parameter int WIDTH = ualu_pkg::DEF_WIDTH
) (
    input  wire                     i_clk,
    input  wire ualu_pkg::t_unit_cmd i_cmd,
    input  wire  [WIDTH-1:0]        i_x,
    input  wire  [WIDTH-1:0]        i_y,
    output logic [WIDTH-1:0]        o_hi,
    output logic [WIDTH-1:0]        o_lo,
    output logic                    o_cy
);

    logic [WIDTH-1:0] r_hi, n_hi;
    logic [WIDTH-1:0] r_lo, n_lo;
    logic [WIDTH-1:0] r_op, n_op;
    logic             r_cy, n_cy;

    logic [WIDTH:0]   ax;
    logic [WIDTH-1:0] bx;
    logic             inv;
    logic [WIDTH+1:0] b_ext;
    logic [WIDTH+1:0] sum;
    logic [WIDTH:0]   mul_shift;
    logic [WIDTH:0]   div_shift;

    // One adder serves the add, subtract, multiply and divide steps; subtraction adds the inverted operand plus one.
    always_comb begin
        ax    = (i_cmd.code == ualu_pkg::UC_DIV) ? {r_hi, r_lo[WIDTH-1]} : {1'b0, r_hi};
        bx    = (i_cmd.code == ualu_pkg::UC_MUL) ? (r_lo[0] ? r_op : '0) : r_op;
        inv   = (i_cmd.code == ualu_pkg::UC_SUB) || (i_cmd.code == ualu_pkg::UC_DIV);
        b_ext = inv ? ~{2'b00, bx} : {2'b00, bx};
        sum   = {1'b0, ax} + b_ext + {{(WIDTH+1){1'b0}}, inv};
        mul_shift = {sum[0], r_lo};
        div_shift = {r_lo, ~sum[WIDTH+1]};
    end

    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        n_op = r_op;
        n_cy = r_cy;
        unique case (i_cmd.code)
            ualu_pkg::UC_NOP: begin
            end
            ualu_pkg::UC_LOAD_HI: begin
                n_hi = i_x;
                n_lo = '0;
                n_op = i_y;
            end
            ualu_pkg::UC_LOAD_LO: begin
                n_hi = '0;
                n_lo = i_x;
                n_op = i_y;
            end
            ualu_pkg::UC_ADD: begin
                n_hi = sum[WIDTH-1:0];
                n_cy = sum[WIDTH];
            end
            ualu_pkg::UC_SUB: begin
                n_hi = sum[WIDTH-1:0];
                n_cy = sum[WIDTH+1];
            end
            ualu_pkg::UC_MUL: begin
                n_hi = sum[WIDTH:1];
                n_lo = mul_shift[WIDTH:1];
            end
            ualu_pkg::UC_DIV: begin
                // Keep the trial difference only when it did not borrow.
                n_hi = sum[WIDTH+1] ? ax[WIDTH-1:0] : sum[WIDTH-1:0];
                n_lo = div_shift[WIDTH-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        r_op <= n_op;
        r_cy <= n_cy;
    end

    assign o_hi = r_hi;
    assign o_lo = r_lo;
    assign o_cy = r_cy;

endmodule

`default_nettype wire

### rtl/unsigned_alu_mul_div_factorial_core.sv
// Top level: sequencer around the shared arithmetic unit, with a registered result word.
// Sequence: an accepted word passes the load, run and check states; multiply and divide repeat
// the run state once per bit. A zero divisor, an unused action or a factorial of 0 or 1 skips
// the run state; factorial of n >= 2 runs the multiply loop for each factor up to the last used.
// Throughput: one word at a time, set by the one-bit-per-cycle loop of the shared unit; the
// next word is taken from the edge after the result word loads. Output stalls add on top.
// Reset: synchronous, active low; clears the sequencer and the result valid, no data.
`default_nettype none

module unsigned_alu_mul_div_factorial_core #(
    parameter int WIDTH = ualu_pkg::DEF_WIDTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ualu_in_if.sink       i_in,
    ualu_out_if.source    o_res
);

    // The step counter must hold WIDTH-1.
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [ualu_pkg::ACT_W-1:0]   r_act;
    logic [WIDTH-1:0]             r_a;
    logic [WIDTH-1:0]             r_b;
    logic [WIDTH-1:0]             r_i, n_i;
    logic [CNT_W-1:0]             r_cnt, n_cnt;

    logic                         r_out_valid;
    logic [ualu_pkg::FIELD_W-1:0] r_out_result, n_out_result;
    logic [ualu_pkg::FIELD_W-1:0] r_out_rem, n_out_rem;
    logic                         r_out_flag, n_out_flag;
    logic                         r_out_dbz, n_out_dbz;
    logic                         load_out;

    ualu_pkg::t_unit_cmd          ucmd;
    logic [WIDTH-1:0]             ux, uy;
    logic [WIDTH-1:0]             u_hi, u_lo;
    logic                         u_cy;

    logic                         in_acc;
    logic                         slot_free;
    logic                         a_small;
    logic                         b_zero;
    logic                         hi_nz;
    logic                         fact_more;

    ualu_unit #(
        .WIDTH (WIDTH)
    ) u_unit (
        .i_clk (i_clk),
        .i_cmd (ucmd),
        .i_x   (ux),
        .i_y   (uy),
        .o_hi  (u_hi),
        .o_lo  (u_lo),
        .o_cy  (u_cy)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_res.ready;

    // Factorial of 0 or 1 is 1 and needs no multiply at all.
    assign a_small   = ({1'b0, r_a} < (WIDTH+1)'(2));
    assign b_zero    = (r_b == '0);
    assign hi_nz     = (u_hi != '0);
    // Another factor is needed while the product still fits and the last factor is not reached.
    assign fact_more = (r_act == ualu_pkg::ACT_FACT) && !a_small && !hi_nz && (r_i != r_a);

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_cnt        = r_cnt;
        ucmd.code    = ualu_pkg::UC_NOP;
        ux           = '0;
        uy           = '0;
        load_out     = 1'b0;
        n_out_result = '0;
        n_out_rem    = '0;
        n_out_flag   = 1'b0;
        n_out_dbz    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_RUN;
                n_cnt   = CNT_LAST;
                case (r_act) inside
                    ualu_pkg::ACT_ADD, ualu_pkg::ACT_SUB: begin
                        ucmd.code = ualu_pkg::UC_LOAD_HI;
                        ux        = r_a;
                        uy        = r_b;
                        n_cnt     = '0;
                    end
                    ualu_pkg::ACT_MUL: begin
                        ucmd.code = ualu_pkg::UC_LOAD_LO;
                        ux        = r_a;
                        uy        = r_b;
                    end
                    ualu_pkg::ACT_DIV: begin
                        if (b_zero) begin
                            n_state = ST_CHECK;
                        end else begin
                            ucmd.code = ualu_pkg::UC_LOAD_LO;
                            ux        = r_a;
                            uy        = r_b;
                        end
                    end
                    ualu_pkg::ACT_FACT: begin
                        if (a_small) begin
                            n_state = ST_CHECK;
                        end else begin
                            // First product is 1 times 2.
                            ucmd.code = ualu_pkg::UC_LOAD_LO;
                            ux        = WIDTH'(2);
                            uy        = WIDTH'(1);
                            n_i       = WIDTH'(2);
                        end
                    end
                    default: begin
                        n_state = ST_CHECK;
                    end
                endcase
            end
            ST_RUN: begin
                case (r_act)
                    ualu_pkg::ACT_ADD: ucmd.code = ualu_pkg::UC_ADD;
                    ualu_pkg::ACT_SUB: ucmd.code = ualu_pkg::UC_SUB;
                    ualu_pkg::ACT_DIV: ucmd.code = ualu_pkg::UC_DIV;
                    default:           ucmd.code = ualu_pkg::UC_MUL;
                endcase
                if (r_cnt == '0) begin
                    n_state = ST_CHECK;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_CHECK: begin
                if (fact_more) begin
                    // Next factor multiplies the running product held in the low half.
                    ucmd.code = ualu_pkg::UC_LOAD_LO;
                    ux        = r_i + WIDTH'(1);
                    uy        = u_lo;
                    n_i       = r_i + WIDTH'(1);
                    n_cnt     = CNT_LAST;
                    n_state   = ST_RUN;
                end else if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    case (r_act) inside
                        ualu_pkg::ACT_ADD, ualu_pkg::ACT_SUB: begin
                            n_out_result = ualu_pkg::FIELD_W'(u_hi);
                            n_out_flag   = u_cy;
                        end
                        ualu_pkg::ACT_MUL: begin
                            n_out_result = ualu_pkg::FIELD_W'(u_lo);
                            n_out_flag   = hi_nz;
                        end
                        ualu_pkg::ACT_DIV: begin
                            if (b_zero) begin
                                n_out_dbz = 1'b1;
                            end else begin
                                n_out_result = ualu_pkg::FIELD_W'(u_lo);
                                n_out_rem    = ualu_pkg::FIELD_W'(u_hi);
                            end
                        end
                        ualu_pkg::ACT_FACT: begin
                            if (a_small) begin
                                n_out_result = ualu_pkg::FIELD_W'(1);
                            end else begin
                                n_out_result = ualu_pkg::FIELD_W'(u_lo);
                                n_out_flag   = hi_nz;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operand capture, counters and the result word carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act <= i_in.action;
            r_a   <= WIDTH'(i_in.operand_a);
            r_b   <= WIDTH'(i_in.operand_b);
        end
        r_i   <= n_i;
        r_cnt <= n_cnt;
        if (load_out) begin
            r_out_result <= n_out_result;
            r_out_rem    <= n_out_rem;
            r_out_flag   <= n_out_flag;
            r_out_dbz    <= n_out_dbz;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result      = r_out_result;
    assign o_res.remainder   = r_out_rem;
    assign o_res.flag        = r_out_flag;
    assign o_res.div_by_zero = r_out_dbz;

endmodule

`default_nettype wire

### rtl/ualu_checker.sv
// Port-level assertions for the ALU core and the bind that attaches them.
`default_nettype none

module ualu_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               i_in_ready,
    input wire                               i_out_valid,
    input wire                               i_out_ready,
    input wire [ualu_pkg::FIELD_W-1:0]       i_out_result,
    input wire [ualu_pkg::FIELD_W-1:0]       i_out_rem,
    input wire                               i_out_flag,
    input wire                               i_out_dbz
);

    // A result word is never withdrawn before it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // Only one word is in work: the input side closes right after an acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a word is in work");

    // A zero divisor gives zero for every other field.
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dbz |-> (i_out_result == '0) && (i_out_rem == '0) && !i_out_flag)
        else $error("divide by zero word carries data");

    // Reset leaves no result word pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind unsigned_alu_mul_div_factorial_core ualu_checker u_ualu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_result (o_res.result),
    .i_out_rem    (o_res.remainder),
    .i_out_flag   (o_res.flag),
    .i_out_dbz    (o_res.div_by_zero)
);

`default_nettype wire
